// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BSRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define BSRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/bsrc_pkg.sv -----
package bsrc_pkg;

  localparam int MAP_DIM_DEF = 64;
  localparam int ROW_W       = 64;
  localparam int COL_W       = $clog2(ROW_W);
  localparam int IDX_W       = 6;
  localparam int VIEW_W      = 6;
  localparam int END_W       = 7;
  localparam int OCT_W       = 3;
  localparam int TILE_W      = 8;
  localparam int STEP_W      = 6;
  localparam int D_W         = 16;
  localparam int DIFF_W      = END_W + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y = 1'b1;

  localparam logic [STEP_W-1:0] MAX_STEPS = '1;

  // octant codes, named after the mapping of (rx, ry) onto the map
  localparam logic [OCT_W-1:0] OCT_XP_YP = 3'd0;
  localparam logic [OCT_W-1:0] OCT_SW_PP = 3'd1;
  localparam logic [OCT_W-1:0] OCT_SW_PM = 3'd2;
  localparam logic [OCT_W-1:0] OCT_XM_YP = 3'd3;
  localparam logic [OCT_W-1:0] OCT_XM_YM = 3'd4;
  localparam logic [OCT_W-1:0] OCT_SW_MM = 3'd5;
  localparam logic [OCT_W-1:0] OCT_SW_MP = 3'd6;
  localparam logic [OCT_W-1:0] OCT_XP_YM = 3'd7;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_CAST  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_CAST
  } bk_state_t;

  typedef struct packed {
    cmd_t               command;
    logic [IDX_W-1:0]   row_index;
    logic [ROW_W-1:0]   row_bits;
    logic [END_W-1:0]   end_x;
    logic [END_W-1:0]   end_y;
    logic [OCT_W-1:0]   octant;
  } in_item_t;

  typedef struct packed {
    logic signed [TILE_W-1:0] tile_x;
    logic signed [TILE_W-1:0] tile_y;
    logic                     in_map;
    logic                     blocks_sight;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic signed [TILE_W-1:0] x;
    logic signed [TILE_W-1:0] y;
  } point_t;

  // reflect or swap a first-octant offset about the viewer
  function automatic point_t oct_map(logic [OCT_W-1:0] oct, logic [VIEW_W-1:0] hx,
                                     logic [VIEW_W-1:0] hy, logic [STEP_W-1:0] rx,
                                     logic [STEP_W-1:0] ry);
    logic signed [TILE_W-1:0] sx;
    logic signed [TILE_W-1:0] sy;
    logic signed [TILE_W-1:0] a;
    logic signed [TILE_W-1:0] b;
    point_t p;
    sx = TILE_W'(hx);
    sy = TILE_W'(hy);
    a  = TILE_W'(rx);
    b  = TILE_W'(ry);
    unique case (oct)
      OCT_XP_YP: begin p.x = sx + a; p.y = sy + b; end
      OCT_SW_PP: begin p.x = sx + b; p.y = sy + a; end
      OCT_SW_PM: begin p.x = sx + b; p.y = sy - a; end
      OCT_XM_YP: begin p.x = sx - a; p.y = sy + b; end
      OCT_XM_YM: begin p.x = sx - a; p.y = sy - b; end
      OCT_SW_MM: begin p.x = sx - b; p.y = sy - a; end
      OCT_SW_MP: begin p.x = sx - b; p.y = sy + a; end
      OCT_XP_YM: begin p.x = sx + a; p.y = sy - b; end
      default:   begin p.x = sx + a; p.y = sy - b; end
    endcase
    return p;
  endfunction

endpackage

// ----- sv/bsrc_front.sv -----
module bsrc_front #(
  parameter int MAP_DIM = bsrc_pkg::MAP_DIM_DEF
) (
  input  logic               start,
  input  bsrc_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               busy,
  output logic               q_push
);

  logic accept;
  logic row_ok;

  assign busy   = q_full;
  assign accept = start && !q_full;

  // writes to rows past the map are taken and dropped here
  assign row_ok = ({1'b0, in_item.row_index} < (bsrc_pkg::IDX_W + 1)'(MAP_DIM));
  assign q_push = accept && ((in_item.command == bsrc_pkg::CMD_CAST) || row_ok);

endmodule

// ----- sv/bsrc_queue.sv -----
module bsrc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bsrc_pkg::in_item_t push_data,
  input  logic               pop,
  output bsrc_pkg::in_item_t pop_data,
  output logic               full,
  output logic               empty
);

  localparam int DEPTH = bsrc_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  bsrc_pkg::in_item_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/bsrc_back.sv -----
module bsrc_back #(
  parameter int MAP_DIM = bsrc_pkg::MAP_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bsrc_pkg::VIEW_W-1:0]   viewer_x,
  input  logic [bsrc_pkg::VIEW_W-1:0]   viewer_y,
  input  logic                          q_empty,
  input  bsrc_pkg::in_item_t            q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  output bsrc_pkg::out_item_t           out_item
);

  localparam int RW = (MAP_DIM > 1) ? $clog2(MAP_DIM) : 1;
  localparam logic [bsrc_pkg::TILE_W-1:0] DIM_T = bsrc_pkg::TILE_W'(MAP_DIM);

  bsrc_pkg::bk_state_t state_r, state_nxt;

  // stepper state
  logic [bsrc_pkg::STEP_W-1:0]     k_r, ry_r, steps_r;
  logic signed [bsrc_pkg::D_W-1:0] d_r, inc_up_r, inc_flat_r;
  logic [bsrc_pkg::OCT_W-1:0]      oct_r;

  // blocking map
  logic [bsrc_pkg::ROW_W-1:0] map_mem [MAP_DIM];
  logic [MAP_DIM-1:0]         row_valid_r;
  logic [bsrc_pkg::ROW_W-1:0] row_rd_r;

  // emit stage
  logic             b_valid_r;
  bsrc_pkg::point_t b_pt_r;
  logic             b_in_r, b_view_r, b_steplast_r, b_rowok_r;

  logic                               load, wr_en, a_issue, kill;
  logic                               is_view, dpos, last_now, pt_on_map, blk;
  logic [bsrc_pkg::STEP_W-1:0]        ry_now;
  logic signed [bsrc_pkg::DIFF_W-1:0] dx, dy;
  logic signed [bsrc_pkg::D_W-1:0]    dxw, dyw;
  logic [bsrc_pkg::STEP_W-1:0]        steps0;
  bsrc_pkg::point_t                   pt;
  logic [RW-1:0]                      rd_addr;
  logic [RW-1:0]                      wr_addr;

  // front end of the ray: set up on pop
  assign dx  = bsrc_pkg::DIFF_W'(q_data.end_x) - bsrc_pkg::DIFF_W'(viewer_x);
  assign dy  = bsrc_pkg::DIFF_W'(q_data.end_y) - bsrc_pkg::DIFF_W'(viewer_y);
  assign dxw = bsrc_pkg::D_W'(dx);
  assign dyw = bsrc_pkg::D_W'(dy);

  always_comb begin
    if (dx < bsrc_pkg::DIFF_W'(2)) begin
      steps0 = '0;
    end else if (dx > bsrc_pkg::DIFF_W'(bsrc_pkg::MAX_STEPS)) begin
      steps0 = bsrc_pkg::MAX_STEPS;
    end else begin
      steps0 = bsrc_pkg::STEP_W'(dx - bsrc_pkg::DIFF_W'(1));
    end
  end

  assign load  = q_pop && (q_data.command == bsrc_pkg::CMD_CAST);
  assign wr_en = q_pop && (q_data.command == bsrc_pkg::CMD_WRITE);
  assign wr_addr = q_data.row_index[RW-1:0];

  // one point per cycle; the viewer tile goes out at k = 0
  assign is_view   = (k_r == '0);
  assign dpos      = (d_r > 0);
  assign ry_now    = is_view ? '0 : ry_r + bsrc_pkg::STEP_W'(dpos);
  assign last_now  = (k_r == steps_r);
  assign pt        = bsrc_pkg::oct_map(oct_r, viewer_x, viewer_y, k_r, ry_now);
  assign pt_on_map = !pt.x[bsrc_pkg::TILE_W-1] && ($unsigned(pt.x) < DIM_T) &&
                     !pt.y[bsrc_pkg::TILE_W-1] && ($unsigned(pt.y) < DIM_T);
  assign rd_addr   = pt_on_map ? pt.y[RW-1:0] : '0;

  // emit stage: a blocked tile ends the ray and drops the point behind it
  assign blk  = b_in_r && !b_view_r && b_rowok_r &&
                row_rd_r[b_pt_r.x[bsrc_pkg::COL_W-1:0]];
  assign kill = b_valid_r && blk && !b_steplast_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsrc_pkg::BK_IDLE: begin
        if (!q_empty && (q_data.command == bsrc_pkg::CMD_CAST)) begin
          state_nxt = bsrc_pkg::BK_CAST;
        end
      end
      bsrc_pkg::BK_CAST: begin
        if (kill || last_now) begin
          state_nxt = bsrc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = bsrc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    a_issue = 1'b0;
    unique case (state_r)
      bsrc_pkg::BK_IDLE: q_pop   = !q_empty;
      bsrc_pkg::BK_CAST: a_issue = !kill;
      default: begin
        q_pop   = 1'b0;
        a_issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsrc_pkg::BK_IDLE;
      b_valid_r   <= 1'b0;
      row_valid_r <= '0;
    end else begin
      state_r   <= state_nxt;
      b_valid_r <= a_issue;
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      k_r        <= '0;
      ry_r       <= '0;
      d_r        <= (dyw <<< 1) - dxw;
      inc_up_r   <= (dyw <<< 1) - (dxw <<< 1);
      inc_flat_r <= dyw <<< 1;
      steps_r    <= steps0;
      oct_r      <= q_data.octant;
    end else if (a_issue) begin
      k_r <= k_r + 1'b1;
      if (!is_view) begin
        ry_r <= ry_now;
        d_r  <= d_r + (dpos ? inc_up_r : inc_flat_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= q_data.row_bits;
    end
    if (a_issue) begin
      row_rd_r <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_issue) begin
      b_pt_r       <= pt;
      b_in_r       <= pt_on_map;
      b_view_r     <= is_view;
      b_steplast_r <= last_now;
      b_rowok_r    <= row_valid_r[rd_addr];
    end
  end

  assign out_valid             = b_valid_r;
  assign out_item.tile_x       = b_pt_r.x;
  assign out_item.tile_y       = b_pt_r.y;
  assign out_item.in_map       = b_in_r;
  assign out_item.blocks_sight = blk;
  assign out_item.last         = blk || b_steplast_r;

endmodule

// ----- sv/bresenham_sight_ray_caster.sv -----
// Sight ray caster over a blocking bitmap of MAP_DIM rows.
// Command channel: start with in_item, taken at an edge where start is high
// and busy is low. A write command (command = 0) loads one map row; a row
// index past the map is taken and dropped. A cast command (command = 1)
// traces a Bresenham ray from the viewer tile and emits one word per tile.
// Config port: cfg_we, cfg_index (0 viewer_x, 1 viewer_y), cfg_wdata; write
// it only while no command is pending.
// Result channel: out_valid strobes one word for one cycle; out_item.last
// marks the final tile of a ray, which is either the blocking tile or the
// last step. The receiver cannot stall and the block never waits on it.
// Flow: a taken command waits in the queue and is popped while the stepper
// idles; a cast then loads the stepper, and each tile is registered into
// the emit stage before its word leaves. A blocking tile cuts a ray short.
// One tile a cycle while a ray is cast, set by the single map read port; a
// ray has at most 64 words. A row write is done as it is popped. A
// two-entry command queue sits in front, so busy rises only while it is full.
// Reset: map reads as all clear, viewer at (0, 0), queue empty, no output.
module bresenham_sight_ray_caster #(
  parameter int MAP_DIM = bsrc_pkg::MAP_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  bsrc_pkg::in_item_t               in_item,
  output logic                             out_valid,
  output bsrc_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [bsrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsrc_pkg::VIEW_W-1:0]      cfg_wdata
);

  logic [bsrc_pkg::VIEW_W-1:0] viewer_x_r;
  logic [bsrc_pkg::VIEW_W-1:0] viewer_y_r;

  logic               q_push, q_pop, q_full, q_empty;
  bsrc_pkg::in_item_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viewer_x_r <= '0;
      viewer_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsrc_pkg::CFG_VIEWER_X: viewer_x_r <= cfg_wdata;
        bsrc_pkg::CFG_VIEWER_Y: viewer_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bsrc_front #(.MAP_DIM(MAP_DIM)) u_front (
    .start   (start),
    .in_item (in_item),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push)
  );

  bsrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (in_item),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bsrc_back #(.MAP_DIM(MAP_DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .viewer_x  (viewer_x_r),
    .viewer_y  (viewer_y_r),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- sv/bsrc_checker.sv -----
`include "assert_macros.svh"

module bsrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input bsrc_pkg::out_item_t out_item
);

  // nothing comes out right after reset
  `BSRC_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "word out after reset")

  // a blocking tile always closes its ray
  `BSRC_ASSERT(a_blk_last, clk, rst_n, out_valid && out_item.blocks_sight |-> out_item.last, "blocking tile not last")

  // only tiles on the map can block
  `BSRC_ASSERT(a_blk_inmap, clk, rst_n, out_valid && out_item.blocks_sight |-> out_item.in_map, "off-map tile blocks")

  // a ray streams one tile per cycle until its last word
  `BSRC_ASSERT(a_ray_dense, clk, rst_n, out_valid && !out_item.last |=> out_valid, "gap inside a ray")

endmodule

bind bresenham_sight_ray_caster bsrc_checker u_bsrc_checker (.*);

// ----- test/bresenham_sight_ray_caster_checker.sv -----
`timescale 1ns / 1ps

module bresenham_sight_ray_caster_checker
  import bsrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VIEW_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   words_pending
);

  logic [ROW_W-1:0]  sight_map [MAP_DIM_DEF];
  logic [VIEW_W-1:0] view_x;
  logic [VIEW_W-1:0] view_y;
  out_item_t         expected_tiles [$];

  function automatic bit on_grid(int px, int py);
    return px >= 0 && px < MAP_DIM_DEF && py >= 0 && py < MAP_DIM_DEF;
  endfunction

  function automatic out_item_t tile_word(int px, int py, bit blk, bit fin);
    out_item_t t;
    t.tile_x       = px[TILE_W-1:0];
    t.tile_y       = py[TILE_W-1:0];
    t.in_map       = on_grid(px, py);
    t.blocks_sight = blk;
    t.last         = fin;
    return t;
  endfunction

  // walks the first-octant line and folds each step into the chosen octant
  task automatic trace_ray(int ex, int ey, logic [OCT_W-1:0] oct);
    int hx;
    int hy;
    int dx;
    int dy;
    int d;
    int y;
    int ry;
    int steps;
    int px;
    int py;
    bit blk;
    hx    = int'(view_x);
    hy    = int'(view_y);
    dx    = ex - hx;
    dy    = ey - hy;
    d     = 2 * dy - dx;
    y     = hy;
    steps = dx - 1;
    if (steps < 0) steps = 0;
    if (steps > int'(MAX_STEPS)) steps = int'(MAX_STEPS);
    // viewer tile never blocks
    expected_tiles.insert(expected_tiles.size(), tile_word(hx, hy, 1'b0, steps == 0));
    for (int k = 1; k <= steps; k++) begin
      if (d > 0) begin
        y++;
        d += 2 * dy - 2 * dx;
      end else begin
        d += 2 * dy;
      end
      ry = y - hy;
      case (oct)
        OCT_XP_YP: begin px = hx + k;  py = hy + ry; end
        OCT_SW_PP: begin px = hx + ry; py = hy + k;  end
        OCT_SW_PM: begin px = hx + ry; py = hy - k;  end
        OCT_XM_YP: begin px = hx - k;  py = hy + ry; end
        OCT_XM_YM: begin px = hx - k;  py = hy - ry; end
        OCT_SW_MM: begin px = hx - ry; py = hy - k;  end
        OCT_SW_MP: begin px = hx - ry; py = hy + k;  end
        default:   begin px = hx + k;  py = hy - ry; end
      endcase
      blk = on_grid(px, py) && sight_map[py[5:0]][px[5:0]];
      expected_tiles.insert(expected_tiles.size(), tile_word(px, py, blk, blk || k == steps));
      if (blk) break;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (sight_map[i]) sight_map[i] = '0;
      view_x = '0;
      view_y = '0;
      expected_tiles.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_tiles.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected word (%0d,%0d) in_map %0b blk %0b last %0b", $time,
                     out_item.tile_x, out_item.tile_y, out_item.in_map,
                     out_item.blocks_sight, out_item.last);
          fail_count++;
        end else begin
          want = expected_tiles.pop_front();
          if (out_item.tile_x !== want.tile_x || out_item.tile_y !== want.tile_y ||
              out_item.in_map !== want.in_map ||
              out_item.blocks_sight !== want.blocks_sight ||
              out_item.last !== want.last) begin
            if (fail_count < 10) begin
              $write("%0t: word mismatch: got (%0d,%0d) in_map %0b blk %0b last %0b,", $time,
                     out_item.tile_x, out_item.tile_y, out_item.in_map,
                     out_item.blocks_sight, out_item.last);
              $display(" expected (%0d,%0d) in_map %0b blk %0b last %0b",
                       want.tile_x, want.tile_y, want.in_map, want.blocks_sight,
                       want.last);
            end
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_item.command == CMD_WRITE) begin
          if (int'(in_item.row_index) < MAP_DIM_DEF)
            sight_map[in_item.row_index] = in_item.row_bits;
        end else begin
          trace_ray(int'(in_item.end_x), int'(in_item.end_y), in_item.octant);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_VIEWER_X: view_x = cfg_wdata;
          CFG_VIEWER_Y: view_y = cfg_wdata;
          default: ;
        endcase
      end
    end
    words_pending = expected_tiles.size();
  end

endmodule

// ----- test/bresenham_sight_ray_caster_tb.sv -----
`timescale 1ns / 1ps

module bresenham_sight_ray_caster_tb;
  import bsrc_pkg::*;

  localparam logic [OCT_W-1:0] ALL_OCTANTS [8] = '{OCT_XP_YP, OCT_SW_PP, OCT_SW_PM, OCT_XM_YP,
                                                 OCT_XM_YM, OCT_SW_MM, OCT_SW_MP, OCT_XP_YM};
  localparam int PHASE_IDLE [4] = '{0, 86, 37, 0};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  in_item_t             in_item   = '0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VIEW_W-1:0]    cfg_wdata = '0;
  logic                 busy;
  logic                 out_valid;
  out_item_t            out_item;
  int                   fail_count;
  int                   words_pending;
  int                   idle_pct = 0;
  int                   vx = 0;
  int                   vy = 0;

  always #1 clk = ~clk;

  bresenham_sight_ray_caster u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bresenham_sight_ray_caster_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // start stays high after a taken word; the next call lowers or reloads it
  task automatic issue(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // fields unused by a command carry random junk
  task automatic write_row(int row, logic [ROW_W-1:0] bits);
    in_item_t it;
    it           = '0;
    it.command   = CMD_WRITE;
    it.row_index = IDX_W'(row);
    it.row_bits  = bits;
    it.end_x     = END_W'($urandom);
    it.end_y     = END_W'($urandom);
    it.octant    = OCT_W'($urandom);
    issue(it);
  endtask

  task automatic cast_ray(int ex, int ey, logic [OCT_W-1:0] oct);
    in_item_t it;
    it           = '0;
    it.command   = CMD_CAST;
    it.row_index = IDX_W'($urandom);
    it.row_bits  = {$urandom, $urandom};
    it.end_x     = END_W'(ex);
    it.end_y     = END_W'(ey);
    it.octant    = oct;
    issue(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    // row writes leave no word behind, give the queue time to empty
    repeat (10) @(posedge clk);
  endtask

  task automatic set_viewer(int x, int y);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VIEWER_X;
    cfg_wdata <= VIEW_W'(x);
    @(posedge clk);
    cfg_index <= CFG_VIEWER_Y;
    cfg_wdata <= VIEW_W'(y);
    @(posedge clk);
    cfg_we <= 1'b0;
    vx = x;
    vy = y;
  endtask

  function automatic logic [ROW_W-1:0] rand_row();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 64'd1 << $urandom_range(0, 63);
      2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int lenx;
    int span;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_viewer(0, 0);
    write_row(5, 64'd1 << 10);
    cast_ray(127, 0, OCT_XP_YP);
    cast_ray(0, 0, OCT_XP_YP);
    cast_ray(1, 0, OCT_XP_YP);
    cast_ray(127, 127, OCT_SW_PP);
    cast_ray(20, 10, OCT_XP_YP);
    foreach (ALL_OCTANTS[i]) cast_ray(40, 17, ALL_OCTANTS[i]);

    set_viewer(63, 63);
    write_row(62, '1);
    write_row(63, '0);
    foreach (ALL_OCTANTS[i]) cast_ray(100, 80, ALL_OCTANTS[i]);
    // endpoint behind the viewer, then below the diagonal
    cast_ray(0, 127, OCT_XP_YP);
    cast_ray(127, 0, OCT_XM_YM);
    write_row(62, '0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = PHASE_IDLE[p];
      case (p)
        1: set_viewer(0, 63);
        2: set_viewer(63, 0);
        default: set_viewer($urandom_range(0, 63), $urandom_range(0, 63));
      endcase
      repeat (24) begin
        if ($urandom_range(0, 99) < 25) begin
          write_row($urandom_range(0, 63), rand_row());
        end else if ($urandom_range(0, 99) < 85) begin
          // well-formed first-octant endpoint, mostly short rays
          span = 127 - vx;
          if ($urandom_range(0, 3) != 0 && span > 40) span = 40;
          lenx = $urandom_range(0, span);
          span = (lenx < 127 - vy) ? lenx : 127 - vy;
          cast_ray(vx + lenx, vy + $urandom_range(0, span), OCT_W'($urandom_range(0, 7)));
        end else begin
          cast_ray($urandom_range(0, 127), $urandom_range(0, 127),
                   OCT_W'($urandom_range(0, 7)));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("bresenham_sight_ray_caster_tb: done, clean");
    else
      $display("bresenham_sight_ray_caster_tb: done, errors");
    $finish;
  end

  initial begin
    #400000;
    $display("bresenham_sight_ray_caster_tb: done, errors");
    $finish;
  end

endmodule
